// ===== hdl/swst_pkg.sv =====
`timescale 1ns / 1ps

package swst_pkg;

    localparam int SEQ_W      = 10;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int RING_W     = 11;
    localparam int WIN_W      = 10;

    localparam logic [OP_W-1:0] OP_ADD       = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY_PRS = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY_WIN = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_WIN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd2;

    localparam logic [RING_W-1:0] RING_RESET  = 11'd1024;
    localparam logic [WIN_W-1:0]  WIN_RESET   = 10'd64;
    localparam logic [SEQ_W-1:0]  START_RESET = 10'd0;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [SEQ_W-1:0] seq;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                answer;
        logic [SEQ_W-1:0]    head_now;
    } t_out;

    typedef struct packed {
        logic busy;
        logic clr_we;
    } t_init_ctl;

endpackage

// ===== hdl/sliding_window_seq_tracker.sv =====
`timescale 1ns / 1ps

// Sequence receive tracker with a sliding acceptance window over a ring bitmap.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries an opcode and a
// sequence number; output channel (o_out_valid / i_out_ready / o_out_data)
// returns one result per input transfer: status, query answer, head after it.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (0 ring
// size, 1 window size, 2 start head); any valid write clears the bitmap.
// Each input transfer is evaluated in S_EVAL against the bitmap read; an accepted
// add then walks in S_WALK, advancing the head over marked slots and clearing the
// slot one window ahead, and every item ends in S_DONE, which loads the output
// register once it is free.
// The bitmap lives in a single RAM with one read and one write port; each head
// step is one read-modify-write, so the walk length sets the time per item.
// One item is in flight at a time; a new item is taken while a finished result
// still waits in the output register, but its result holds until that clears.
// After reset or a configuration write the block sweeps the bitmap clear and
// reduces start head modulo the effective ring size, with o_in_ready low until
// both are done.
// When the receiver stalls, the pending result holds and the next item stops
// before its result stage.

module sliding_window_seq_tracker import swst_pkg::*; #(
    parameter int RING_DEPTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = (AW + 1 > CFG_DATA_W) ? AW + 1 : CFG_DATA_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    t_init_ctl     init_ctl;
    logic [AW-1:0] clr_addr;
    logic [AW-1:0] head_init;
    logic [CW-1:0] eff_ring;
    logic [CW-1:0] eff_win;

    logic [1:0]          r_state, n_state;
    logic [OP_W-1:0]     r_op;
    logic [SEQ_W-1:0]    r_seq;
    logic [AW-1:0]       r_head, n_head;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_answer, n_answer;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;
    logic                r_fw_hit;
    logic                r_fw_data;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic          mem_q;

    logic          item_we;
    logic [AW-1:0] item_waddr;
    logic          item_wdata;
    logic          in_xfer;

    logic [CW-1:0] seq_in_c;
    logic [CW-1:0] seq_c;
    logic [CW-1:0] head_c;
    logic [CW:0]   off_sum;
    logic [CW:0]   off;
    logic          in_win;
    logic [CW:0]   hw_sum;
    logic [CW:0]   hw_mod;
    logic [CW-1:0] head_inc_c;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] far_addr;
    logic          marked;

    swst_cfg #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW),
        .CW         (CW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ctl       (init_ctl),
        .o_clr_addr  (clr_addr),
        .o_head_init (head_init),
        .o_eff_ring  (eff_ring),
        .o_eff_win   (eff_win)
    );

    swst_bitmap_ram #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    assign o_in_ready = (r_state == S_IDLE) && !init_ctl.busy;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        seq_in_c = CW'(i_in_data.seq);
        seq_c    = CW'(r_seq);
        head_c   = CW'(r_head);

        off_sum = (CW+1)'(seq_c) + (CW+1)'(eff_ring) - (CW+1)'(head_c);
        off     = (off_sum >= (CW+1)'(eff_ring)) ? off_sum - (CW+1)'(eff_ring) : off_sum;
        in_win  = (seq_c < eff_ring) && (off < (CW+1)'(eff_win));

        hw_sum   = (CW+1)'(head_c) + (CW+1)'(eff_win);
        hw_mod   = (hw_sum >= (CW+1)'(eff_ring)) ? hw_sum - (CW+1)'(eff_ring) : hw_sum;
        far_addr = hw_mod[AW-1:0];

        head_inc_c = (head_c + CW'(1) == eff_ring) ? '0 : head_c + CW'(1);
        head_inc   = head_inc_c[AW-1:0];

        marked = r_fw_hit ? r_fw_data : mem_q;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_status    = r_status;
        n_answer    = r_answer;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        item_we     = 1'b0;
        item_waddr  = '0;
        item_wdata  = 1'b0;
        mem_raddr   = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                mem_raddr = seq_in_c[AW-1:0];
                if (in_xfer) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_status = ST_OK;
                n_answer = 1'b0;
                n_state  = S_DONE;
                case (r_op)
                    OP_ADD: begin
                        if (!in_win) begin
                            n_status = ST_OUT_WIN;
                        end else if (marked) begin
                            n_status = ST_DUP;
                        end else begin
                            item_we    = 1'b1;
                            item_waddr = seq_c[AW-1:0];
                            item_wdata = 1'b1;
                            mem_raddr  = r_head;
                            n_state    = S_WALK;
                        end
                    end
                    OP_QUERY_PRS: n_answer = in_win && marked;
                    OP_QUERY_WIN: n_answer = in_win;
                    default:      n_answer = 1'b0;
                endcase
            end
            S_WALK: begin
                if (marked) begin
                    item_we    = 1'b1;
                    item_waddr = far_addr;
                    item_wdata = 1'b0;
                    n_head     = head_inc;
                    mem_raddr  = head_inc;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid     = 1'b1;
                    n_out.status    = r_status;
                    n_out.answer    = r_answer;
                    n_out.head_now  = head_c[SEQ_W-1:0];
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (init_ctl.busy) begin
            n_head = head_init;
        end
    end

    always_comb begin
        if (init_ctl.clr_we) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr;
            mem_wdata = 1'b0;
        end else begin
            mem_we    = item_we;
            mem_waddr = item_waddr;
            mem_wdata = item_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head    <= n_head;
        r_status  <= n_status;
        r_answer  <= n_answer;
        r_out     <= n_out;
        r_fw_hit  <= mem_we && (mem_waddr == mem_raddr);
        r_fw_data <= mem_wdata;
        if (in_xfer) begin
            r_op  <= i_in_data.opcode;
            r_seq <= i_in_data.seq;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/swst_bitmap_ram.sv =====
`timescale 1ns / 1ps

module swst_bitmap_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [DEPTH];
    logic r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== hdl/swst_cfg.sv =====
`timescale 1ns / 1ps

module swst_cfg import swst_pkg::*; #(
    parameter int RING_DEPTH = 1024,
    parameter int AW         = 10,
    parameter int CW         = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_init_ctl             o_ctl,
    output logic [AW-1:0]         o_clr_addr,
    output logic [AW-1:0]         o_head_init,
    output logic [CW-1:0]         o_eff_ring,
    output logic [CW-1:0]         o_eff_win
);

    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
    localparam logic [CW-1:0] MIN_C   = CW'(2);
    localparam logic [AW-1:0] LAST_C  = AW'(RING_DEPTH - 1);

    logic [RING_W-1:0] r_ring;
    logic [WIN_W-1:0]  r_win;
    logic [SEQ_W-1:0]  r_start;
    logic              r_busy;
    logic              r_pend;
    logic              r_clr_done;
    logic [AW-1:0]     r_clr_cnt;
    logic [CW-1:0]     r_hmod;
    logic [CW-1:0]     r_eff_ring;
    logic [CW-1:0]     r_eff_win;

    logic [CW-1:0] ring_c;
    logic [CW-1:0] win_c;
    logic [CW-1:0] eff_ring_c;
    logic [CW-1:0] eff_win_c;
    logic          cfg_hit;

    always_comb begin
        ring_c = CW'(r_ring);
        win_c  = CW'(r_win);
        if (ring_c < MIN_C) begin
            eff_ring_c = MIN_C;
        end else if (ring_c > DEPTH_C) begin
            eff_ring_c = DEPTH_C;
        end else begin
            eff_ring_c = ring_c;
        end
        if (win_c > eff_ring_c - CW'(1)) begin
            eff_win_c = eff_ring_c - CW'(1);
        end else begin
            eff_win_c = win_c;
        end
    end

    always_comb begin
        unique case (i_cfg_index)
            CFG_RING_SIZE, CFG_WIN_SIZE, CFG_START_HEAD: cfg_hit = i_cfg_we;
            default:                                     cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring     <= RING_RESET;
            r_win      <= WIN_RESET;
            r_start    <= START_RESET;
            r_busy     <= 1'b1;
            r_pend     <= 1'b1;
            r_clr_done <= 1'b0;
            r_clr_cnt  <= '0;
        end else if (cfg_hit) begin
            unique case (i_cfg_index)
                CFG_RING_SIZE:  r_ring  <= i_cfg_data[RING_W-1:0];
                CFG_WIN_SIZE:   r_win   <= i_cfg_data[WIN_W-1:0];
                CFG_START_HEAD: r_start <= i_cfg_data[SEQ_W-1:0];
                default:        r_ring  <= r_ring;
            endcase
            r_busy     <= 1'b1;
            r_pend     <= 1'b1;
            r_clr_done <= 1'b0;
            r_clr_cnt  <= '0;
        end else if (r_busy) begin
            if (!r_clr_done) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
                if (r_clr_cnt == LAST_C) begin
                    r_clr_done <= 1'b1;
                end
            end
            if (r_pend) begin
                r_pend <= 1'b0;
            end else if (r_clr_done && r_hmod < eff_ring_c) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eff_ring <= eff_ring_c;
        r_eff_win  <= eff_win_c;
        if (r_pend) begin
            r_hmod <= CW'(r_start);
        end else if (r_hmod >= eff_ring_c) begin
            r_hmod <= r_hmod - eff_ring_c;
        end
    end

    assign o_ctl.busy   = r_busy;
    assign o_ctl.clr_we = r_busy && !r_clr_done;
    assign o_clr_addr   = r_clr_cnt;
    assign o_head_init  = r_hmod[AW-1:0];
    assign o_eff_ring   = r_eff_ring;
    assign o_eff_win    = r_eff_win;

endmodule

// ===== dv/sliding_window_seq_tracker_chk.sv =====
`timescale 1ns / 1ps

module sliding_window_seq_tracker_chk import swst_pkg::*; #(
    parameter int RING_DEPTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in                   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out                  i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_cnt,
    output int                    o_pending,
    output int                    o_adds_ok,
    output int                    o_dups,
    output int                    o_oow
);

    logic [RING_W-1:0] ring_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [SEQ_W-1:0]  start_reg;
    logic              rx_map [RING_DEPTH];
    int unsigned       head;
    t_out              status_q [$];
    int                fails;
    int                adds_ok;
    int                dups;
    int                oow;

    function automatic int unsigned ring_eff();
        int unsigned r;
        r = ring_reg;
        if (r < 2) r = 2;
        if (r > RING_DEPTH) r = RING_DEPTH;
        return r;
    endfunction

    function automatic void restart_window();
        foreach (rx_map[k]) rx_map[k] = 1'b0;
        head = start_reg % ring_eff();
    endfunction

    function automatic bit seq_in_window(int unsigned s, int unsigned r, int unsigned w);
        if (s >= r) return 1'b0;
        return ((s + r - head) % r) < w;
    endfunction

    // Mark or look up one sequence number and slide the window over received slots.
    function automatic t_out track_seq(t_in item);
        int unsigned r;
        int unsigned w;
        int unsigned s;
        t_out        res;
        r = ring_eff();
        w = (win_reg > r - 1) ? r - 1 : win_reg;
        s = item.seq;
        res.status = ST_OK;
        res.answer = 1'b0;
        head = head % r;
        case (item.opcode)
            OP_ADD: begin
                if (!seq_in_window(s, r, w)) begin
                    res.status = ST_OUT_WIN;
                end else if (rx_map[s]) begin
                    res.status = ST_DUP;
                end else begin
                    rx_map[s] = 1'b1;
                    while (rx_map[head]) begin
                        rx_map[(head + w) % r] = 1'b0;
                        head = (head + 1) % r;
                    end
                end
            end
            OP_QUERY_PRS: res.answer = seq_in_window(s, r, w) && rx_map[s];
            OP_QUERY_WIN: res.answer = seq_in_window(s, r, w);
            default: ;
        endcase
        res.head_now = head[SEQ_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out exp_res;
        if (!i_rst_n) begin
            ring_reg  = RING_RESET;
            win_reg   = WIN_RESET;
            start_reg = START_RESET;
            restart_window();
            status_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RING_SIZE: begin
                        ring_reg = i_cfg_data;
                        restart_window();
                    end
                    CFG_WIN_SIZE: begin
                        win_reg = i_cfg_data[WIN_W-1:0];
                        restart_window();
                    end
                    CFG_START_HEAD: begin
                        start_reg = i_cfg_data[SEQ_W-1:0];
                        restart_window();
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                exp_res = track_seq(i_in_data);
                status_q.push_back(exp_res);
                if (i_in_data.opcode == OP_ADD) begin
                    if (exp_res.status == ST_OK) adds_ok++;
                    else if (exp_res.status == ST_DUP) dups++;
                    else oow++;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (status_q.size() == 0) begin
                    $error("unexpected result transfer: status %0d answer %0d head_now %0d",
                           i_out_data.status, i_out_data.answer, i_out_data.head_now);
                    fails++;
                end else begin
                    exp_res = status_q.pop_front();
                    if (i_out_data.status !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d",
                               exp_res.status, i_out_data.status);
                        fails++;
                    end
                    if (i_out_data.answer !== exp_res.answer) begin
                        $error("answer: expected %0d, actual %0d",
                               exp_res.answer, i_out_data.answer);
                        fails++;
                    end
                    if (i_out_data.head_now !== exp_res.head_now) begin
                        $error("head_now: expected %0d, actual %0d",
                               exp_res.head_now, i_out_data.head_now);
                        fails++;
                    end
                end
            end
        end
        o_pending  <= status_q.size();
        o_fail_cnt <= fails + status_q.size() * 0;
        o_adds_ok  <= adds_ok;
        o_dups     <= dups;
        o_oow      <= oow;
    end

endmodule

// ===== dv/sliding_window_seq_tracker_tb.sv =====
`timescale 1ns / 1ps

module sliding_window_seq_tracker_tb;
    import swst_pkg::*;

    localparam int N_SETTINGS   = 9;
    localparam int RAND_PER_SET = 75;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_RING_SIZE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int fail_cnt;
    int pending;
    int adds_ok;
    int dups;
    int oow;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_kick      = 0;
    int          kick_seen      = 0;
    int          hold_left      = 0;
    int unsigned cycles         = 0;
    int unsigned sent           = 0;
    int unsigned ring_now       = 1024;
    int unsigned win_now        = 64;
    logic [SEQ_W-1:0] head_seen = '0;

    logic [CFG_DATA_W-1:0] ring_tab  [N_SETTINGS] =
        '{11'd2, 11'd1024, 11'd16, 11'd0, 11'd100, 11'd37, 11'd2047, 11'd1024, 11'd64};
    logic [CFG_DATA_W-1:0] win_tab   [N_SETTINGS] =
        '{11'd1, 11'd1023, 11'd8, 11'd1029, 11'd200, 11'd0, 11'd32, 11'd64, 11'd63};
    logic [CFG_DATA_W-1:0] start_tab [N_SETTINGS] =
        '{11'd1023, 11'd1023, 11'd5, 11'd0, 11'd700, 11'd3, 11'd1000, 11'd512, 11'd63};

    sliding_window_seq_tracker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    sliding_window_seq_tracker_chk chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending),
        .o_adds_ok   (adds_ok),
        .o_dups      (dups),
        .o_oow       (oow)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sliding_window_seq_tracker regression: fail");
            $finish;
        end
    end

    // Result side: random stalls plus one long hold-off.
    always @(posedge i_clk) begin
        if (hold_kick != kick_seen) begin
            kick_seen = hold_kick;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (o_out_valid && i_out_ready) head_seen <= o_out_data.head_now;
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq);
        int   gap;
        t_in  item;
        gap = 0;
        item.opcode = op;
        item.seq    = seq;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] ring,
                              input logic [CFG_DATA_W-1:0] win,
                              input logic [CFG_DATA_W-1:0] start);
        drain();
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_RING_SIZE;
        i_cfg_data  <= ring;
        @(posedge i_clk);
        i_cfg_index <= CFG_WIN_SIZE;
        i_cfg_data  <= win;
        @(posedge i_clk);
        i_cfg_index <= CFG_START_HEAD;
        i_cfg_data  <= start;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ring_now = (ring < 2) ? 2 : (ring > 1024) ? 1024 : ring;
        win_now  = win[WIN_W-1:0];
        if (win_now > ring_now - 1) win_now = ring_now - 1;
    endtask

    // Mostly adds just ahead of the head so the window keeps sliding.
    task automatic send_random();
        int unsigned      pick;
        int unsigned      base;
        int unsigned      s;
        logic [OP_W-1:0]  op;
        base = head_seen % ring_now;
        pick = $urandom_range(99);
        if (pick < 60) op = OP_ADD;
        else if (pick < 78) op = OP_QUERY_PRS;
        else if (pick < 96) op = OP_QUERY_WIN;
        else op = OP_UNUSED;
        pick = $urandom_range(99);
        if (pick < 50) s = (base + $urandom_range(win_now < 8 ? win_now : 8)) % ring_now;
        else if (pick < 75) s = (base + $urandom_range(win_now + 1)) % ring_now;
        else if (pick < 85) s = (base + ring_now - $urandom_range(4, 1)) % ring_now;
        else s = $urandom_range(1023);
        send_item(op, s[SEQ_W-1:0]);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_QUERY_WIN, 10'd0);
        send_item(OP_QUERY_WIN, 10'd63);
        send_item(OP_QUERY_WIN, 10'd64);
        send_item(OP_QUERY_PRS, 10'd0);
        send_item(OP_ADD,       10'd1);
        send_item(OP_ADD,       10'd1);
        send_item(OP_QUERY_PRS, 10'd1);
        send_item(OP_ADD,       10'd0);
        send_item(OP_ADD,       10'd65);
        send_item(OP_ADD,       10'd66);
        send_item(OP_ADD,       10'd1023);
        send_item(OP_ADD,       10'd1);
        send_item(OP_UNUSED,    10'd1023);
        send_item(OP_ADD,       10'd2);
        send_item(OP_ADD,       10'd3);
        send_item(OP_ADD,       10'd4);
        send_item(OP_QUERY_PRS, 10'd65);
        send_item(OP_QUERY_WIN, 10'd1023);
        send_item(OP_QUERY_PRS, 10'd1023);
        send_item(OP_ADD,       10'h2AA);
        send_item(OP_ADD,       10'h155);

        for (int k = 0; k < N_SETTINGS; k++) begin
            write_regs(ring_tab[k], win_tab[k], start_tab[k]);
            case (k % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            for (int n = 0; n < RAND_PER_SET; n++) begin
                if (k == 2 && n == RAND_PER_SET / 2) begin
                    // write to the unused index: state must survive
                    drain();
                    repeat (8) @(posedge i_clk);
                    i_cfg_we    <= 1'b1;
                    i_cfg_index <= CFG_SPARE;
                    i_cfg_data  <= '1;
                    @(posedge i_clk);
                    i_cfg_we <= 1'b0;
                end
                if (k == 4 && n == 10) hold_kick <= hold_kick + 1;
                if (k == 6 && n == RAND_PER_SET / 2) drain();
                send_random();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Ran %0d transfers over %0d register settings with four handshake idle mixes.",
                 sent, N_SETTINGS + 1);
        $display("Adds taken %0d, duplicates %0d, out of window %0d.", adds_ok, dups, oow);
        if (fail_cnt == 0) begin
            $display("sliding_window_seq_tracker regression: pass");
        end else begin
            $display("sliding_window_seq_tracker regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/swst_pkg.sv
hdl/swst_bitmap_ram.sv
hdl/swst_cfg.sv
hdl/sliding_window_seq_tracker.sv
dv/sliding_window_seq_tracker_chk.sv
dv/sliding_window_seq_tracker_tb.sv
